[rtl/reti_pkg.sv]
// ----------------------------------------------------------------------------
// reti_pkg
// Shared types and constants for the ranked entry table.
// ----------------------------------------------------------------------------
package reti_pkg;

    localparam int DEF_TABLE_DEPTH = 128;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_READ   = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_UNUSED = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_RSVD  = 2'd3
    } t_status;

    typedef struct packed {
        logic [31:0] ip;
        logic [15:0] port;
        logic [7:0]  clients;
        logic [7:0]  limit;
        logic [7:0]  bots;
        logic [9:0]  lat;
        logic        priv;
    } t_entry;

    // Neighbour link: data and the "new record ranks before me" flag.
    typedef struct packed {
        t_entry data;
        logic   go;
    } t_link;

endpackage

[rtl/ranked_entry_table_insert_core.sv]
// ----------------------------------------------------------------------------
// ranked_entry_table_insert_core
// Ranked host table kept sorted by a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Channel | Dir | tdata                                    | tuser
// s_axis  | in  | index,ip,port,clients,limit,bots,lat,prv | mode
// m_axis  | out | ip,port,clients,limit,bots,lat,prv,      | status
//         |     | count,player total,insert position       |
//
// The cells compare in the cycle a request is offered and shift on the
// accepting edge, which also loads the output register.
// A new request is taken while the output register is empty or being drained.
// Reset empties the table at once (count and sum cleared); no clearing pass.
// A stalled result holds in the output register and blocks the input.
// ----------------------------------------------------------------------------
module ranked_entry_table_insert_core
    import reti_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [6:0] entry_index, [38:7] host_ip, [54:39] host_port,
    // [62:55] clients, [70:63] client_limit, [78:71] bot_count,
    // [88:79] latency, [89] private_flag, [95:90] zero
    input  logic [95:0]  s_axis_tdata,
    // [1:0] mode
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] out_ip, [47:32] out_port, [55:48] out_clients,
    // [63:56] out_limit, [71:64] out_bots, [81:72] out_latency,
    // [82] out_private, [90:83] entry_count, [106:91] player_total,
    // [113:107] insert_position, [119:114] zero
    output logic [119:0] m_axis_tdata,
    // [1:0] status
    output logic [1:0]   m_axis_tuser
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    t_mode         mode;
    logic [CW-1:0] idx;
    t_entry        new_e;
    logic          accept;
    logic          full;
    logic          do_ins;
    logic          out_range;

    logic [CW-1:0] r_count, n_count;
    logic [15:0]   r_sum, n_sum;
    logic          r_valid;
    t_status       r_status, n_status;
    t_entry        r_rd, n_rd;
    logic [6:0]    r_pos, n_pos;

    t_link         links [TABLE_DEPTH];
    logic          loads [TABLE_DEPTH];
    t_entry        sel_e;
    logic [CW-1:0] pos_acc;

    assign mode          = t_mode'(s_axis_tuser);
    assign idx           = CW'(s_axis_tdata[6:0]);
    assign new_e.ip      = s_axis_tdata[38:7];
    assign new_e.port    = s_axis_tdata[54:39];
    assign new_e.clients = s_axis_tdata[62:55];
    assign new_e.limit   = s_axis_tdata[70:63];
    assign new_e.bots    = s_axis_tdata[78:71];
    assign new_e.lat     = s_axis_tdata[88:79];
    assign new_e.priv    = s_axis_tdata[89];

    assign s_axis_tready = ~r_valid | m_axis_tready;
    assign accept        = s_axis_tvalid & s_axis_tready;
    assign full          = (r_count == CW'(TABLE_DEPTH));
    assign do_ins        = accept & (mode == MODE_INSERT) & ~full;
    assign out_range     = ({25'd0, s_axis_tdata[6:0]} >= 32'(TABLE_DEPTH)) |
                           (idx >= r_count);

    // Cell row: each slot looks left for a shift.
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        t_link left;
        if (g == 0) begin : g_head
            assign left = '0;
        end else begin : g_body
            assign left = links[g-1];
        end
        reti_cell #(.IDX(g), .CW(CW)) u_cell (
            .i_clk    (i_clk),
            .i_insert (do_ins),
            .i_count  (r_count),
            .i_new    (new_e),
            .i_left   (left),
            .o_link   (links[g]),
            .o_load   (loads[g])
        );
    end

    // Read select and landing rank, both as AND-OR over the row.
    always_comb begin
        sel_e   = '0;
        pos_acc = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (CW'(i) == idx) begin
                sel_e = sel_e | links[i].data;
            end
            if (loads[i]) begin
                pos_acc = pos_acc | CW'(i);
            end
        end
    end

    always_comb begin
        n_count  = r_count;
        n_sum    = r_sum;
        n_status = ST_OK;
        n_rd     = '0;
        n_pos    = '0;
        unique case (mode)
            MODE_INSERT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                    n_sum   = r_sum + {8'd0, new_e.clients} - {8'd0, new_e.bots};
                    n_pos   = 7'(pos_acc);
                end
            end
            MODE_READ: begin
                if (out_range) begin
                    n_status = ST_RANGE;
                end else begin
                    n_rd = sel_e;
                end
            end
            MODE_CLEAR: begin
                n_count = '0;
                n_sum   = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count <= n_count;
                r_sum   <= n_sum;
                r_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Hold the result until it is taken.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_rd     <= n_rd;
            r_pos    <= n_pos;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = {6'd0, r_pos, r_sum, 8'(r_count), r_rd.priv, r_rd.lat,
                            r_rd.bots, r_rd.limit, r_rd.clients, r_rd.port, r_rd.ip};

endmodule

[rtl/reti_cell.sv]
// ----------------------------------------------------------------------------
// reti_cell
// One rank slot: compares the new record with its entry, then holds, loads
// the new record or takes its left neighbour's entry.
// ----------------------------------------------------------------------------
module reti_cell
    import reti_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 8
) (
    input  logic          i_clk,
    input  logic          i_insert,
    input  logic [CW-1:0] i_count,
    input  t_entry        i_new,
    input  t_link         i_left,
    output t_link         o_link,
    output logic          o_load
);

    t_entry      r_entry;
    logic        occ;
    logic        rb;
    logic        shift;
    logic signed [8:0] hn;
    logic signed [8:0] he;

    assign occ = (CW'(IDX) < i_count);
    assign hn  = $signed({1'b0, i_new.clients}) - $signed({1'b0, i_new.bots});
    assign he  = $signed({1'b0, r_entry.clients}) - $signed({1'b0, r_entry.bots});

    always_comb begin
        if (hn != he) begin
            rb = (hn > he);
        end else if (i_new.clients != r_entry.clients) begin
            rb = (i_new.clients > r_entry.clients);
        end else begin
            rb = (i_new.lat < r_entry.lat);
        end
    end

    assign o_link.go   = occ & rb;
    assign o_link.data = r_entry;
    assign shift  = i_insert & i_left.go;
    assign o_load = i_insert & ~i_left.go & (o_link.go | (i_count == CW'(IDX)));

    // Shift right from the neighbour, else drop the new record in here.
    always_ff @(posedge i_clk) begin
        if (shift) begin
            r_entry <= i_left.data;
        end else if (o_load) begin
            r_entry <= i_new;
        end
    end

endmodule

[rtl/reti_checker.sv]
// ----------------------------------------------------------------------------
// reti_checker
// Port-level checks for the ranked entry table, bound to the top level.
// ----------------------------------------------------------------------------
module reti_checker
    import reti_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [119:0] m_axis_tdata,
    input logic [1:0]   m_axis_tuser
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted request gave no result");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ST_FULL |->
        m_axis_tdata[90:83] == 8'(TABLE_DEPTH) && m_axis_tdata[113:107] == 7'd0)
        else $error("full status with wrong count");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ST_RANGE |-> m_axis_tdata[82:0] == '0)
        else $error("out of range read carries data");

endmodule

bind ranked_entry_table_insert_core reti_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_reti_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

[tb/sv/ranked_entry_table_insert_core_chk.sv]
// ----------------------------------------------------------------------------
// ranked_entry_table_insert_core_chk
// Watches both stream channels, keeps a shadow ranked table and compares
// every result with the prediction for the oldest outstanding request.
// ----------------------------------------------------------------------------
module ranked_entry_table_insert_core_chk
    import reti_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_req_valid,
    input  logic         i_req_ready,
    input  logic [95:0]  i_req_data,
    input  logic [1:0]   i_req_user,
    input  logic         i_rsp_valid,
    input  logic         i_rsp_ready,
    input  logic [119:0] i_rsp_data,
    input  logic [1:0]   i_rsp_user,
    output int           o_errors,
    output int           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]   status;
        logic [119:0] data;
    } t_result;

    t_entry         shadow_table [TABLE_DEPTH];
    int             shadow_count;
    logic [15:0]    shadow_humans;
    t_result        awaited_results [$];

    function automatic bit outranks(t_entry n, t_entry e);
        int hn;
        int he;
        hn = int'(n.clients) - int'(n.bots);
        he = int'(e.clients) - int'(e.bots);
        if (hn != he) return hn > he;
        if (n.clients != e.clients) return n.clients > e.clients;
        return n.lat < e.lat;
    endfunction

    task automatic apply_request(logic [1:0] mode, logic [95:0] d);
        t_entry  rec;
        t_entry  rd;
        t_result r;
        int      pos;
        logic [6:0] idx;
        rd = '0;
        pos = 0;
        r.status = ST_OK;
        idx = d[6:0];
        rec.ip = d[38:7];
        rec.port = d[54:39];
        rec.clients = d[62:55];
        rec.limit = d[70:63];
        rec.bots = d[78:71];
        rec.lat = d[88:79];
        rec.priv = d[89];
        case (mode)
            MODE_INSERT: begin
                if (shadow_count >= TABLE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    pos = shadow_count;
                    for (int i = 0; i < shadow_count; i++) begin
                        if (outranks(rec, shadow_table[i])) begin
                            pos = i;
                            break;
                        end
                    end
                    for (int i = shadow_count; i > pos; i--)
                        shadow_table[i] = shadow_table[i-1];
                    shadow_table[pos] = rec;
                    shadow_count++;
                    shadow_humans = shadow_humans + 16'(rec.clients) - 16'(rec.bots);
                end
            end
            MODE_READ: begin
                if (idx >= shadow_count) r.status = ST_RANGE;
                else rd = shadow_table[idx];
            end
            MODE_CLEAR: begin
                shadow_count = 0;
                shadow_humans = '0;
            end
            default: ;
        endcase
        r.data = {6'd0, 7'(pos), shadow_humans, 8'(shadow_count), rd.priv, rd.lat,
                  rd.bots, rd.limit, rd.clients, rd.port, rd.ip};
        awaited_results.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_result exp_r;
        if (!i_rst_n) begin
            shadow_count = 0;
            shadow_humans = '0;
            o_errors = 0;
            awaited_results.delete();
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (awaited_results.size() == 0) begin
                    o_errors++;
                    $display("%0t: unexpected result %h/%h", $time, i_rsp_user, i_rsp_data);
                end else begin
                    exp_r = awaited_results.pop_front();
                    if (exp_r.status !== i_rsp_user) begin
                        o_errors++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_r.status, i_rsp_user);
                    end
                    if (exp_r.data !== i_rsp_data) begin
                        o_errors++;
                        $display("%0t: data expected %h actual %h",
                                 $time, exp_r.data, i_rsp_data);
                    end
                end
            end
            if (i_req_valid && i_req_ready) apply_request(i_req_user, i_req_data);
        end
        o_pending = awaited_results.size();
    end
endmodule

[tb/sv/ranked_entry_table_insert_core_tb.sv]
// ----------------------------------------------------------------------------
// ranked_entry_table_insert_core_tb
// Drives directed and random table requests with random gaps on both sides,
// including a long downstream hold-off, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module ranked_entry_table_insert_core_tb;
    import reti_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = DEF_TABLE_DEPTH;
    localparam int CYCLE_LIMIT = 400000;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // [6:0] index, [38:7] ip, [54:39] port, [62:55] clients, [70:63] limit,
    // [78:71] bots, [88:79] latency, [89] private, [95:90] zero
    logic [95:0]  s_axis_tdata;
    // [1:0] mode
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // [31:0] ip, [47:32] port, [55:48] clients, [63:56] limit, [71:64] bots,
    // [81:72] latency, [82] private, [90:83] count, [106:91] player total,
    // [113:107] insert position, [119:114] zero
    logic [119:0] m_axis_tdata;
    // [1:0] status
    logic [1:0]   m_axis_tuser;

    int errors;
    int pending;
    int cycles;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_off;

    ranked_entry_table_insert_core #(.TABLE_DEPTH(DEPTH)) dut (.*);

    ranked_entry_table_insert_core_chk #(.TABLE_DEPTH(DEPTH)) u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(s_axis_tvalid), .i_req_ready(s_axis_tready),
        .i_req_data(s_axis_tdata), .i_req_user(s_axis_tuser),
        .i_rsp_valid(m_axis_tvalid), .i_rsp_ready(m_axis_tready),
        .i_rsp_data(m_axis_tdata), .i_rsp_user(m_axis_tuser),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Abort a hung run.
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("ranked_entry_table_insert_core_tb: errors");
                $finish;
            end
        end
    end

    // Downstream ready: random back-pressure, or held low during a hold-off.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Present one request and hold it until accepted; idle gaps come first.
    task automatic send_request(t_mode mode, logic [95:0] payload);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {6'd0, payload[89:0]};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [95:0] make_record(logic [7:0] cl, logic [7:0] bt,
                                                logic [9:0] lat);
        return {6'd0, 1'($urandom), lat, bt, 8'($urandom), cl, 16'($urandom),
                32'($urandom), 7'($urandom)};
    endfunction

    function automatic logic [95:0] make_index(logic [6:0] idx);
        logic [95:0] d;
        d = {$urandom, $urandom, $urandom};
        d[6:0] = idx;
        return d;
    endfunction

    // Pick a random request; inserts dominate so the table fills and ranks deeply.
    task automatic random_request();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55)
            send_request(MODE_INSERT, make_record(8'($urandom_range(40)),
                                                  8'($urandom_range(40)),
                                                  $urandom_range(4) == 0 ?
                                                  10'($urandom_range(999)) :
                                                  10'($urandom_range(3))));
        else if (pick < 62)
            send_request(MODE_INSERT, {$urandom, $urandom, $urandom});
        else if (pick < 92)
            send_request(MODE_READ, make_index(7'($urandom_range(127))));
        else if (pick < 95)
            send_request(MODE_CLEAR, {$urandom, $urandom, $urandom});
        else
            send_request(MODE_UNUSED, {$urandom, $urandom, $urandom});
    endtask

    initial begin
        int drain;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = MODE_INSERT;
        hold_off = 1'b0;
        send_idle_pct = 32;
        recv_idle_pct = 53;
        i_rst_n = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty reads, extremes, equal keys, negative humans, mode 3.
        send_request(MODE_READ, make_index(7'd0));
        send_request(MODE_INSERT, make_record(8'd0, 8'd0, 10'd0));
        send_request(MODE_INSERT, {6'd0, 90'h3FF_FFFF_FFFF_FFFF_FFFF_FFFF});
        send_request(MODE_INSERT, {6'd0, 1'b1, 10'd999, 8'hFF, 8'hFF, 8'hFF,
                                   16'hFFFF, 32'hFFFF_FFFF, 7'h7F});
        send_request(MODE_INSERT, make_record(8'd5, 8'd2, 10'd10));
        send_request(MODE_INSERT, make_record(8'd5, 8'd2, 10'd10));
        send_request(MODE_INSERT, make_record(8'd5, 8'd2, 10'd9));
        send_request(MODE_INSERT, make_record(8'd6, 8'd3, 10'd10));
        send_request(MODE_INSERT, make_record(8'd3, 8'd200, 10'd1));
        send_request(MODE_INSERT, make_record(8'd255, 8'd0, 10'd999));
        for (int i = 0; i < 10; i++) send_request(MODE_READ, make_index(7'(i)));
        send_request(MODE_READ, make_index(7'h7F));
        send_request(MODE_UNUSED, {6'd0, 90'h3FF_FFFF_FFFF_FFFF_FFFF_FFFF});
        send_request(MODE_CLEAR, '0);
        send_request(MODE_READ, make_index(7'd0));

        // Fill to the limit, overflow, read the last rank, then clear.
        for (int i = 0; i < DEPTH + 3; i++)
            send_request(MODE_INSERT, make_record(8'($urandom_range(255)),
                                                  8'($urandom_range(255)),
                                                  10'($urandom_range(999))));
        send_request(MODE_READ, make_index(7'(DEPTH - 1)));
        send_request(MODE_CLEAR, '0);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 53 : 0;
            recv_idle_pct = (phase == 0) ? 53 : (phase == 1) ? 32 : 0;
            for (int n = 0; n < 520; n++) begin
                // Long hold-off mid-phase: drop ready while requests keep coming.
                if (phase == 0 && n == 200) begin
                    fork
                        begin
                            hold_off = 1'b1;
                            repeat (150) @(posedge i_clk);
                            hold_off = 1'b0;
                        end
                    join_none
                end
                random_request();
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        drain = 0;
        while (drain < 20) begin
            @(posedge i_clk);
            drain++;
        end
        if (errors == 0)
            $display("ranked_entry_table_insert_core_tb: clean");
        else
            $display("ranked_entry_table_insert_core_tb: errors");
        $finish;
    end
endmodule
